// ----- rtl/uvs_pkg.sv -----
package uvs_pkg;

   localparam int MAX_SEGMENTS = 64;
   localparam int FRAC_BITS    = 16;

   localparam int UV_W       = FRAC_BITS + 1;
   localparam int SEG_CFG_W  = 7;
   localparam int IDX_W      = 12;
   localparam int POS_W      = $clog2(MAX_SEGMENTS);
   localparam int PHI_W      = $clog2(MAX_SEGMENTS + 1);
   localparam int PU_W       = POS_W + UV_W;
   localparam int PV_W       = PHI_W + UV_W;
   localparam int SUM_W      = PV_W + 1;
   localparam int CNR_W      = 3;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = UV_W;

   localparam int MIN_RING  = 3;
   localparam int MIN_STACK = 2;

   localparam logic [UV_W-1:0] UV_ONE = UV_W'(1) << FRAC_BITS;

   localparam logic [SEG_CFG_W-1:0] RESET_RING      = SEG_CFG_W'(3);
   localparam logic [SEG_CFG_W-1:0] RESET_STACK     = SEG_CFG_W'(2);
   localparam logic [UV_W-1:0]      RESET_INV_RING  = UV_W'(21845);
   localparam logic [UV_W-1:0]      RESET_INV_STACK = UV_W'(32768);

   localparam logic [CSR_IDX_W-1:0] CSR_RING_SEGMENTS  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_STACK_SEGMENTS = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_INV_RING       = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_INV_STACK      = 2'd3;

   localparam logic [1:0] REGION_TOP    = 2'd0;
   localparam logic [1:0] REGION_BODY   = 2'd1;
   localparam logic [1:0] REGION_BOTTOM = 2'd2;
   localparam logic [1:0] REGION_DONE   = 2'd3;

   localparam logic [CNR_W-1:0] LAST_TRI  = CNR_W'(2);
   localparam logic [CNR_W-1:0] LAST_QUAD = CNR_W'(5);

   typedef struct packed {
      logic [PHI_W-1:0] phi;
      logic [PHI_W-1:0] theta;
      logic [UV_W-1:0]  inv_ring;
      logic [UV_W-1:0]  inv_stack;
   } cfg_type;

   typedef struct packed {
      logic [1:0]       region;
      logic [POS_W-1:0] i_pos;
      logic             seam;
      logic             final_tri;
      logic [PU_W-1:0]  pu;
      logic [PV_W-1:0]  pv;
      logic [IDX_W-1:0] pj;
   } desc_type;

   typedef struct packed {
      logic [IDX_W-1:0] idx;
      logic [UV_W-1:0]  u;
      logic [UV_W-1:0]  v;
   } corner_type;

endpackage

// ----- rtl/uvs_req_if.sv -----
interface uvs_req_if import uvs_pkg::*; ();
   logic valid;
   logic ready;
   logic restart;

   modport source (output valid, output restart, input ready);
   modport sink (input valid, input restart, output ready);
endinterface

// ----- rtl/uvs_rsp_if.sv -----
interface uvs_rsp_if import uvs_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [IDX_W-1:0] vertex_index;
   logic [UV_W-1:0]  tex_u;
   logic [UV_W-1:0]  tex_v;
   logic             last_corner;
   logic             mesh_done;

   modport source (output valid, output vertex_index, output tex_u, output tex_v,
                   output last_corner, output mesh_done, input ready);
   modport sink (input valid, input vertex_index, input tex_u, input tex_v,
                 input last_corner, input mesh_done, output ready);
endinterface

// ----- rtl/uvs_walker.sv -----
module uvs_walker import uvs_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  cfg_type  cfg,
   uvs_req_if.sink  req,
   output desc_type desc,
   output logic     desc_valid,
   input  logic     desc_ready
);

   logic [1:0]         region_ff, region_in;
   logic [POS_W-1:0]   seg_ff, seg_in;
   logic [POS_W-1:0]   ring_ff, ring_in;
   desc_type           desc_ff, desc_in;
   logic               desc_valid_ff, desc_valid_in;

   logic               accept;
   logic [1:0]         reg_cur;
   logic [POS_W-1:0]   seg_cur, ring_cur, i_pos, j_pos, j_eff;
   logic [PHI_W-1:0]   phi_m1, theta_m3, mul_a, k_v;
   logic [2*PHI_W-1:0] pj_full;
   logic               seam, body_last;

   assign req.ready  = !desc_valid_ff || desc_ready;
   assign accept     = req.valid && req.ready;
   assign desc       = desc_ff;
   assign desc_valid = desc_valid_ff;

   always_comb begin
      reg_cur  = req.restart ? REGION_TOP : region_ff;
      seg_cur  = req.restart ? '0 : seg_ff;
      ring_cur = req.restart ? '0 : ring_ff;
      phi_m1   = cfg.phi - PHI_W'(1);
      theta_m3 = cfg.theta - PHI_W'(3);
      if (reg_cur == REGION_BODY && cfg.theta < PHI_W'(MIN_STACK + 1)) begin
         reg_cur = REGION_BOTTOM;
         seg_cur = '0;
      end
      i_pos     = (PHI_W'(seg_cur) > phi_m1) ? POS_W'(phi_m1) : seg_cur;
      j_pos     = (PHI_W'(ring_cur) > theta_m3) ? POS_W'(theta_m3) : ring_cur;
      seam      = (PHI_W'(i_pos) == phi_m1);
      body_last = (PHI_W'(j_pos) >= theta_m3);
      j_eff     = (reg_cur == REGION_BODY) ? j_pos : '0;

      region_in = region_ff;
      seg_in    = seg_ff;
      ring_in   = ring_ff;
      if (accept) begin
         region_in = reg_cur;
         seg_in    = seg_cur;
         ring_in   = ring_cur;
         case (reg_cur)
            REGION_TOP: begin
               if (seam) begin
                  seg_in    = '0;
                  ring_in   = '0;
                  region_in = (cfg.theta > PHI_W'(MIN_STACK)) ? REGION_BODY : REGION_BOTTOM;
               end else begin
                  seg_in = i_pos + POS_W'(1);
               end
            end
            REGION_BODY: begin
               if (seam) begin
                  seg_in = '0;
                  if (body_last) begin
                     ring_in   = '0;
                     region_in = REGION_BOTTOM;
                  end else begin
                     ring_in = j_pos + POS_W'(1);
                  end
               end else begin
                  seg_in  = i_pos + POS_W'(1);
                  ring_in = j_pos;
               end
            end
            REGION_BOTTOM: begin
               if (seam) begin
                  seg_in    = '0;
                  region_in = REGION_DONE;
               end else begin
                  seg_in = i_pos + POS_W'(1);
               end
            end
            default: begin
            end
         endcase
      end

      mul_a             = (reg_cur == REGION_BOTTOM) ? cfg.theta - PHI_W'(1) : PHI_W'(j_eff);
      k_v               = PHI_W'(j_eff) + PHI_W'(1);
      pj_full           = (2*PHI_W)'(mul_a) * (2*PHI_W)'(cfg.phi);
      desc_in.region    = reg_cur;
      desc_in.i_pos     = i_pos;
      desc_in.seam      = seam;
      desc_in.final_tri = (reg_cur == REGION_BOTTOM) && seam;
      desc_in.pu        = PU_W'(i_pos) * PU_W'(cfg.inv_ring);
      desc_in.pv        = PV_W'(k_v) * PV_W'(cfg.inv_stack);
      desc_in.pj        = IDX_W'(pj_full);

      if (accept) begin
         desc_valid_in = (reg_cur != REGION_DONE);
      end else if (desc_ready) begin
         desc_valid_in = 1'b0;
      end else begin
         desc_valid_in = desc_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         region_ff     <= REGION_TOP;
         seg_ff        <= '0;
         ring_ff       <= '0;
         desc_valid_ff <= 1'b0;
      end else begin
         region_ff     <= region_in;
         seg_ff        <= seg_in;
         ring_ff       <= ring_in;
         desc_valid_ff <= desc_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         desc_ff <= desc_in;
      end
   end

   assert property (@(posedge clock) disable iff (reset)
      region_ff == REGION_DONE |-> seg_ff == '0)
      else $error("finished sphere left a segment position");

   assert property (@(posedge clock) disable iff (reset)
      desc_valid_ff && desc_ff.final_tri |-> desc_ff.region == REGION_BOTTOM && desc_ff.seam)
      else $error("final triangle outside the bottom cap seam");

   assert property (@(posedge clock) disable iff (reset)
      accept && !req.restart && region_ff == REGION_DONE |=> region_ff == REGION_DONE)
      else $error("advance left the finished state");

endmodule

// ----- rtl/uvs_corner.sv -----
module uvs_corner import uvs_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  cfg_type   cfg,
   input  desc_type  desc,
   input  logic      desc_valid,
   output logic      desc_ready,
   uvs_rsp_if.source rsp
);

   function automatic logic [UV_W-1:0] sat_top(input logic [SUM_W-1:0] x);
      return (x > SUM_W'(UV_ONE)) ? UV_ONE : UV_W'(x);
   endfunction

   function automatic logic [UV_W-1:0] one_minus(input logic [SUM_W-1:0] x);
      return (x > SUM_W'(UV_ONE)) ? '0 : UV_W'(SUM_W'(UV_ONE) - x);
   endfunction

   corner_type       table_ff [0:5];
   corner_type       table_in [0:5];
   logic [CNR_W-1:0] last_ff, last_in;
   logic             final_ff;
   logic [CNR_W-1:0] cnt_ff, cnt_in;
   logic             emit_valid_ff, emit_valid_in;

   logic             rsp_valid_ff, rsp_valid_in;
   logic [IDX_W-1:0] rsp_idx_ff;
   logic [UV_W-1:0]  rsp_u_ff, rsp_v_ff;
   logic             rsp_last_ff, rsp_done_ff;

   logic             out_free, fire, last_fire, load;
   logic [UV_W-1:0]  uh, ua_n, ub_n, uclose, useam, ua, ub, uf, v1, v2, vb;
   logic [IDX_W-1:0] ipl, phi_x, south, a_idx, b_idx, c_idx, d_idx;

   assign out_free   = !rsp_valid_ff || rsp.ready;
   assign fire       = emit_valid_ff && out_free;
   assign last_fire  = fire && (cnt_ff == last_ff);
   assign desc_ready = !emit_valid_ff || last_fire;
   assign load       = desc_valid && desc_ready;

   always_comb begin
      uh     = sat_top(SUM_W'(desc.pu) + SUM_W'(cfg.inv_ring >> 1));
      ua_n   = sat_top(SUM_W'(desc.pu));
      ub_n   = sat_top(SUM_W'(desc.pu) + SUM_W'(cfg.inv_ring));
      uclose = UV_ONE - (cfg.inv_ring >> 1);
      useam  = one_minus(SUM_W'(cfg.inv_ring));
      ua     = desc.seam ? useam : ua_n;
      ub     = desc.seam ? UV_ONE : ub_n;
      uf     = desc.seam ? uclose : uh;
      v1     = one_minus(SUM_W'(desc.pv));
      v2     = one_minus(SUM_W'(desc.pv) + SUM_W'(cfg.inv_stack));
      vb     = sat_top(SUM_W'(cfg.inv_stack));
      ipl    = IDX_W'(desc.i_pos);
      phi_x  = IDX_W'(cfg.phi);
      south  = desc.pj + IDX_W'(1);
      a_idx  = desc.seam ? phi_x + desc.pj : IDX_W'(1) + ipl + desc.pj;
      b_idx  = a_idx + phi_x;
      c_idx  = desc.seam ? IDX_W'(1) + desc.pj + phi_x : b_idx + IDX_W'(1);
      d_idx  = desc.seam ? IDX_W'(1) + desc.pj : a_idx + IDX_W'(1);

      for (int k = 0; k < 6; k++) begin
         table_in[k] = '0;
      end
      last_in = LAST_TRI;
      case (desc.region)
         REGION_TOP: begin
            table_in[0] = '{idx: '0, u: uf, v: UV_ONE};
            table_in[1] = '{idx: desc.seam ? phi_x : ipl + IDX_W'(1), u: ua, v: v1};
            table_in[2] = '{idx: desc.seam ? IDX_W'(1) : ipl + IDX_W'(2), u: ub, v: v1};
         end
         REGION_BODY: begin
            table_in[0] = '{idx: a_idx, u: ua, v: v1};
            table_in[1] = '{idx: b_idx, u: ua, v: v2};
            table_in[2] = '{idx: c_idx, u: ub, v: v2};
            table_in[3] = '{idx: a_idx, u: ua, v: v1};
            table_in[4] = '{idx: c_idx, u: ub, v: v2};
            table_in[5] = '{idx: d_idx, u: ub, v: v1};
            last_in     = LAST_QUAD;
         end
         default: begin
            table_in[0] = '{idx: south, u: uf, v: '0};
            table_in[1] = '{idx: desc.seam ? south - phi_x : south - phi_x + ipl + IDX_W'(1),
                            u: ub, v: vb};
            table_in[2] = '{idx: desc.seam ? south - IDX_W'(1) : south - phi_x + ipl,
                            u: ua, v: vb};
         end
      endcase

      if (load) begin
         emit_valid_in = 1'b1;
         cnt_in        = '0;
      end else if (last_fire) begin
         emit_valid_in = 1'b0;
         cnt_in        = cnt_ff;
      end else begin
         emit_valid_in = emit_valid_ff;
         cnt_in        = fire ? cnt_ff + CNR_W'(1) : cnt_ff;
      end

      if (fire) begin
         rsp_valid_in = 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         emit_valid_ff <= 1'b0;
         cnt_ff        <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         emit_valid_ff <= emit_valid_in;
         cnt_ff        <= cnt_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         for (int k = 0; k < 6; k++) begin
            table_ff[k] <= table_in[k];
         end
         last_ff  <= last_in;
         final_ff <= desc.final_tri;
      end
      if (fire) begin
         rsp_idx_ff  <= table_ff[cnt_ff].idx;
         rsp_u_ff    <= table_ff[cnt_ff].u;
         rsp_v_ff    <= table_ff[cnt_ff].v;
         rsp_last_ff <= (cnt_ff == last_ff);
         rsp_done_ff <= (cnt_ff == last_ff) && final_ff;
      end
   end

   assign rsp.valid        = rsp_valid_ff;
   assign rsp.vertex_index = rsp_idx_ff;
   assign rsp.tex_u        = rsp_u_ff;
   assign rsp.tex_v        = rsp_v_ff;
   assign rsp.last_corner  = rsp_last_ff;
   assign rsp.mesh_done    = rsp_done_ff;

   assert property (@(posedge clock) disable iff (reset)
      emit_valid_ff |-> cnt_ff <= last_ff)
      else $error("corner count ran past the last corner");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_done_ff |-> rsp_last_ff)
      else $error("mesh end flagged on a corner that is not last of its beat");

   assert property (@(posedge clock) disable iff (reset)
      last_fire && !load |=> !emit_valid_ff)
      else $error("emitter still busy after its last corner");

endmodule

// ----- rtl/uv_sphere_index_uv_generator.sv -----
// UV sphere corner stream. Each req beat (restart = 1 begins a new sphere) yields one triangle
// as 3 rsp beats or one body quad as 6 rsp beats, each carrying a vertex index and U/V in
// unsigned Q1.16; once the bottom cap closes, further advances yield nothing until a restart.
// The rsp channel delivers one corner per cycle, unless rsp ready is low, from a single output
// register. A req beat is registered as a descriptor, then loaded into the corner table, then into
// the output register; one further req beat is taken while the current corners drain.
// Counts are clamped to 3..64 (ring) and 2..64 (stack); reciprocals are used as written.
// Write the csr registers only while the block is idle.
module uv_sphere_index_uv_generator import uvs_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   uvs_req_if.sink               req_chan,
   uvs_rsp_if.source             rsp_chan,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   logic [SEG_CFG_W-1:0] ring_seg_ff, stack_seg_ff;
   logic [UV_W-1:0]      inv_ring_ff, inv_stack_ff;
   cfg_type              cfg;
   desc_type             desc;
   logic                 desc_valid, desc_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         ring_seg_ff  <= RESET_RING;
         stack_seg_ff <= RESET_STACK;
         inv_ring_ff  <= RESET_INV_RING;
         inv_stack_ff <= RESET_INV_STACK;
      end else if (csr_we) begin
         case (csr_index)
            CSR_RING_SEGMENTS:  ring_seg_ff  <= csr_wdata[SEG_CFG_W-1:0];
            CSR_STACK_SEGMENTS: stack_seg_ff <= csr_wdata[SEG_CFG_W-1:0];
            CSR_INV_RING:       inv_ring_ff  <= csr_wdata[UV_W-1:0];
            CSR_INV_STACK:      inv_stack_ff <= csr_wdata[UV_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      if (int'(ring_seg_ff) < MIN_RING) begin
         cfg.phi = PHI_W'(MIN_RING);
      end else if (int'(ring_seg_ff) > MAX_SEGMENTS) begin
         cfg.phi = PHI_W'(MAX_SEGMENTS);
      end else begin
         cfg.phi = PHI_W'(ring_seg_ff);
      end
      if (int'(stack_seg_ff) < MIN_STACK) begin
         cfg.theta = PHI_W'(MIN_STACK);
      end else if (int'(stack_seg_ff) > MAX_SEGMENTS) begin
         cfg.theta = PHI_W'(MAX_SEGMENTS);
      end else begin
         cfg.theta = PHI_W'(stack_seg_ff);
      end
      cfg.inv_ring  = inv_ring_ff;
      cfg.inv_stack = inv_stack_ff;
   end

   uvs_walker u_walker (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .req        (req_chan),
      .desc       (desc),
      .desc_valid (desc_valid),
      .desc_ready (desc_ready)
   );

   uvs_corner u_corner (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .desc       (desc),
      .desc_valid (desc_valid),
      .desc_ready (desc_ready),
      .rsp        (rsp_chan)
   );

endmodule
